// ===== rtl/ustar_pkg.sv =====
// ----------------------------------------------------------------------------
// ustar_pkg
// shared constants, codes and the result record of the ustar header scanner
// ----------------------------------------------------------------------------
package ustar_pkg;

	localparam int BLOCK_INDEX_BITS_DEF = 32;

	localparam int POS_W        = 9;
	localparam int SIZE_W       = 33;
	localparam int SKIP_W       = 24;
	localparam int TYPE_W       = 8;
	localparam int DATA_BLOCK_W = 32;
	localparam int KIND_W       = 2;
	localparam int MAGIC_LEN    = 5;
	localparam int MAGIC_IDX_W  = 3;

	localparam logic [POS_W-1:0] POS_FIRST       = 9'd0;
	localparam logic [POS_W-1:0] POS_SIZE_FIRST  = 9'd124;
	localparam logic [POS_W-1:0] POS_SIZE_LAST   = 9'd134;
	localparam logic [POS_W-1:0] POS_TYPE        = 9'd156;
	localparam logic [POS_W-1:0] POS_MAGIC_FIRST = 9'd257;
	localparam logic [POS_W-1:0] POS_MAGIC_LAST  = 9'd261;
	localparam logic [POS_W-1:0] POS_LAST        = 9'd511;
	localparam int               BLOCK_SHIFT     = 9;

	localparam logic [1:0] PHASE_HEADER = 2'd0;
	localparam logic [1:0] PHASE_DATA   = 2'd1;
	localparam logic [1:0] PHASE_STOP   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_FILE      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD_MAGIC = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD_DIGIT = 2'd3;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] MAX_OCTAL = 8'd7;

	localparam logic [7:0] MAGIC_TEXT [MAGIC_LEN] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [SIZE_W-1:0]       file_size;
		logic [TYPE_W-1:0]       type_flag;
		logic [DATA_BLOCK_W-1:0] data_block;
	} ustar_result_t;

endpackage

// ===== rtl/ustar_scan_core.sv =====
// ----------------------------------------------------------------------------
// ustar_scan_core
// per-byte scan state: block position, phase, size digits, type, magic and
// data block skip; forms the header result at the last byte of a header
// ----------------------------------------------------------------------------
module ustar_scan_core
	import ustar_pkg::*;
#(
	parameter int BLOCK_INDEX_BITS = BLOCK_INDEX_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    data_byte,
	input  logic          restart,
	output logic          emit,
	output ustar_result_t result
);

	logic [POS_W-1:0]            pos_q, pos_e, pos_n;
	logic [1:0]                  phase_q, phase_e, phase_n;
	logic [SIZE_W-1:0]           size_q, size_e, size_n, size_m1;
	logic [TYPE_W-1:0]           type_q, type_e, type_n;
	logic                        magic_ok_q, magic_ok_e, magic_ok_n;
	logic                        first_q, first_e, first_n;
	logic                        lead_zero_q, lead_zero_e, lead_zero_n;
	logic                        digit_err_q, digit_err_e, digit_err_n;
	logic [SKIP_W-1:0]           skip_q, skip_e, skip_n;
	logic [BLOCK_INDEX_BITS-1:0] idx_q, idx_e, idx_n, idx_inc;
	logic [7:0]                  digit;
	logic [POS_W-1:0]            magic_off;
	logic                        last;

	always_comb begin
		pos_e       = restart ? '0 : pos_q;
		phase_e     = restart ? PHASE_HEADER : phase_q;
		size_e      = restart ? '0 : size_q;
		type_e      = restart ? '0 : type_q;
		magic_ok_e  = restart ? 1'b1 : magic_ok_q;
		first_e     = restart ? 1'b1 : first_q;
		lead_zero_e = restart ? 1'b0 : lead_zero_q;
		digit_err_e = restart ? 1'b0 : digit_err_q;
		skip_e      = restart ? '0 : skip_q;
		idx_e       = restart ? '0 : idx_q;

		pos_n       = pos_e;
		phase_n     = phase_e;
		size_n      = size_e;
		type_n      = type_e;
		magic_ok_n  = magic_ok_e;
		first_n     = first_e;
		lead_zero_n = lead_zero_e;
		digit_err_n = digit_err_e;
		skip_n      = skip_e;
		idx_n       = idx_e;

		last      = (pos_e == POS_LAST);
		digit     = data_byte - CHAR_ZERO;
		magic_off = pos_e - POS_MAGIC_FIRST;
		idx_inc   = idx_e + BLOCK_INDEX_BITS'(1);
		size_m1   = size_e - SIZE_W'(1);

		emit              = 1'b0;
		result.kind       = KIND_FILE;
		result.file_size  = '0;
		result.type_flag  = type_e;
		result.data_block = DATA_BLOCK_W'(idx_e);

		if (phase_e == PHASE_HEADER) begin
			if (pos_e == POS_FIRST) begin
				lead_zero_n = (data_byte == 8'd0);
			end
			if (pos_e >= POS_SIZE_FIRST && pos_e <= POS_SIZE_LAST) begin
				if (digit > MAX_OCTAL) begin
					digit_err_n = 1'b1;
				end
				size_n = {size_e[SIZE_W-4:0], digit[2:0]};
			end
			if (pos_e == POS_TYPE) begin
				type_n = data_byte;
			end
			if (first_e && pos_e >= POS_MAGIC_FIRST && pos_e <= POS_MAGIC_LAST) begin
				if (data_byte != MAGIC_TEXT[magic_off[MAGIC_IDX_W-1:0]]) begin
					magic_ok_n = 1'b0;
				end
			end
			if (last) begin
				emit = 1'b1;
				if (first_e && !magic_ok_e) begin
					result.kind = KIND_BAD_MAGIC;
					phase_n     = PHASE_STOP;
				end else if (lead_zero_e) begin
					result.kind = KIND_END;
					phase_n     = PHASE_STOP;
				end else if (digit_err_e) begin
					result.kind = KIND_BAD_DIGIT;
					phase_n     = PHASE_STOP;
				end else begin
					result.kind       = KIND_FILE;
					result.file_size  = size_e;
					result.data_block = DATA_BLOCK_W'(idx_inc);
					if (size_e == '0) begin
						skip_n = '0;
					end else begin
						skip_n  = size_m1[SIZE_W-1:BLOCK_SHIFT];
						phase_n = PHASE_DATA;
					end
				end
				first_n     = 1'b0;
				size_n      = '0;
				digit_err_n = 1'b0;
				lead_zero_n = 1'b0;
			end
		end else if (phase_e == PHASE_DATA && last) begin
			if (skip_e == '0) begin
				phase_n = PHASE_HEADER;
			end else begin
				skip_n = skip_e - SKIP_W'(1);
			end
		end

		if (phase_e == PHASE_HEADER || phase_e == PHASE_DATA) begin
			if (last) begin
				pos_n = '0;
				idx_n = idx_inc;
			end else begin
				pos_n = pos_e + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			phase_q     <= PHASE_HEADER;
			size_q      <= '0;
			type_q      <= '0;
			magic_ok_q  <= 1'b1;
			first_q     <= 1'b1;
			lead_zero_q <= 1'b0;
			digit_err_q <= 1'b0;
			skip_q      <= '0;
			idx_q       <= '0;
		end else if (advance) begin
			pos_q       <= pos_n;
			phase_q     <= phase_n;
			size_q      <= size_n;
			type_q      <= type_n;
			magic_ok_q  <= magic_ok_n;
			first_q     <= first_n;
			lead_zero_q <= lead_zero_n;
			digit_err_q <= digit_err_n;
			skip_q      <= skip_n;
			idx_q       <= idx_n;
		end
	end

endmodule

// ===== rtl/ustar_archive_header_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// ustar_archive_header_scanner_unit
// streaming scanner of ustar archive headers, one archive byte per beat
// ----------------------------------------------------------------------------
// the slave channel takes the archive image one byte per beat; tuser bit 0
// marks the first byte of a new archive and restarts the scan
// the master channel gives one beat per header block, at its last byte:
// a file entry (size, type flag, first data block), end of archive,
// bad magic in the first header, or a non-octal size digit
// after a file entry the data blocks are skipped; after the three other
// kinds the scan stays stopped and ignores bytes until a restart beat
// each byte is held in an input register, then decoded into the result register
// throughput: one byte per cycle while no result waits on a stalled receiver,
// set by the state update between the input register and the result register
// when the receiver stalls, bytes that make no result keep flowing; a byte
// that would make a result waits in the input register until the result
// register is free
// reset clears the scan to the start of an archive and empties both registers
// ----------------------------------------------------------------------------
module ustar_archive_header_scanner_unit
	import ustar_pkg::*;
#(
	parameter int BLOCK_INDEX_BITS = BLOCK_INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic [0:0]  s_axis_tuser,   // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // file_size, type_flag, data_block, zero pad
	output logic [1:0]  m_axis_tuser    // kind
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          restart_s1;
	logic          out_valid_q;
	ustar_result_t out_res_q;
	logic          emit;
	ustar_result_t result;
	logic          advance;

	ustar_scan_core #(
		.BLOCK_INDEX_BITS(BLOCK_INDEX_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.emit      (emit),
		.result    (result)
	);

	assign advance       = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_res_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tdata  = {7'd0, out_res_q.data_block, out_res_q.type_flag,
		out_res_q.file_size};

endmodule

// ===== rtl/ustar_checker.sv =====
// ----------------------------------------------------------------------------
// ustar_checker
// port-level checks of the ustar header scanner, bound to the top level
// ----------------------------------------------------------------------------
module ustar_checker
	import ustar_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic out_beat;
	logic in_beat;

	assign out_beat = m_axis_tvalid && m_axis_tready;
	assign in_beat  = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_FILE |-> m_axis_tdata[32:0] == '0)
		else $error("nonzero size on a non-file result");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |=> !out_beat)
		else $error("two results in consecutive cycles");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[79:73] == '0)
		else $error("pad bits of result not zero");

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready || in_beat, 2) || $past(!s_axis_tready))
		else $error("result without an accepted byte");

endmodule

bind ustar_archive_header_scanner_unit ustar_checker u_ustar_checker (.*);
